FILE: sv/sdrc_pkg.sv
package sdrc_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] CFG_THRESH  = 3'd0;
	localparam logic [2:0] CFG_SLOPE   = 3'd1;
	localparam logic [2:0] CFG_ATTACK  = 3'd2;
	localparam logic [2:0] CFG_RELEASE = 3'd3;
	localparam logic [2:0] CFG_VOLUME  = 3'd4;
	localparam logic [2:0] CFG_SMOOTH  = 3'd5;

	localparam int CFG_DATA_W = 24;

	// Reset values of the registers and of the state
	localparam logic [21:0] RST_THRESH  = 22'h3F0000;
	localparam logic [15:0] RST_SLOPE   = 16'd32768;
	localparam logic [23:0] RST_ATTACK  = 24'd16700000;
	localparam logic [23:0] RST_RELEASE = 24'd65600;
	localparam logic [23:0] RST_VOLUME  = 24'd1048576;
	localparam logic [23:0] RST_SMOOTH  = 24'd21945;
	localparam logic [24:0] GAIN_ONE    = 25'h1000000;

	// Depth of the queue between front and back
	localparam int QDEPTH = 2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SM1,
		ST_SM2,
		ST_SQRT,
		ST_LEVEL,
		ST_NORM,
		ST_LOG,
		ST_DIFF,
		ST_EXP,
		ST_TARGET,
		ST_GAIN,
		ST_VOL,
		ST_SCL_L,
		ST_SCL_R,
		ST_DONE
	} st_t;

	// Factors 2^(-2^-k), k = 1..16, in Q1.30, made by repeated integer square roots from 0.5.
	typedef logic [29:0] exp_tab_t [16];

	function automatic exp_tab_t exp_roots();
		exp_tab_t t;
		logic [63:0] w;
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bv;
		w = 64'd1 << 29;
		for (int k = 0; k < 16; k++) begin
			x = w << 30;
			res = 64'd0;
			for (int i = 31; i >= 0; i--) begin
				bv = 64'd1 << (2 * i);
				if (x >= res + bv) begin
					x = x - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
			end
			w = res;
			t[k] = w[29:0];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_W = exp_roots();

endpackage

FILE: sv/stereo_dynamic_range_compressor.sv
// Stereo feed-forward compressor with a peak detector. Each input transaction carries one
// stereo sample pair and yields exactly one output transaction with both scaled, saturated
// samples and the gain before volume. A front end takes in pairs, finds their peak
// magnitude and places them in a two-entry queue, so two further pairs can be taken while
// the back end works. The back end is a sequencer around one shared 32 by 32 multiplier;
// for each pair, from taking it off the queue to being ready for the next, it runs 32 steps
// of the bit-serial square root of the smoothed peak, one to 32 steps to normalise the level
// before the logarithm (one per normalising shift, up to 31 for the quietest level, plus
// one), 16 squaring steps for the logarithm and, only when the level is above the threshold,
// 16 product steps and one shift for the power of two. Loud pairs below the threshold take
// the fewest cycles, quiet ones above it the most. Coefficients are to be written through a
// simple write port while the block is idle; the block does not enforce it. No read-back.
module stereo_dynamic_range_compressor #(
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [2:0]                           cfg_index,
	input  logic [sdrc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]       left_in,
	input  logic signed [SAMPLE_WIDTH-1:0]       right_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]       left_out,
	output logic signed [SAMPLE_WIDTH-1:0]       right_out,
	output logic [24:0]                          gain_level
);
	import sdrc_pkg::*;

	// Coefficient registers, all precomputed by software.
	logic [21:0] thresh_q;
	logic [15:0] slope_q;
	logic [23:0] attack_q;
	logic [23:0] release_q;
	logic [23:0] volume_q;
	logic [23:0] smooth_q;

	// Queue interface between the front end and the sequencer.
	logic                          q_pop;
	logic                          q_avail;
	logic signed [SAMPLE_WIDTH-1:0] q_left;
	logic signed [SAMPLE_WIDTH-1:0] q_right;
	logic [31:0]                   q_peak;

	// Writes to an index beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= RST_THRESH;
			slope_q   <= RST_SLOPE;
			attack_q  <= RST_ATTACK;
			release_q <= RST_RELEASE;
			volume_q  <= RST_VOLUME;
			smooth_q  <= RST_SMOOTH;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_THRESH:  thresh_q  <= cfg_data[21:0];
				CFG_SLOPE:   slope_q   <= cfg_data[15:0];
				CFG_ATTACK:  attack_q  <= cfg_data;
				CFG_RELEASE: release_q <= cfg_data;
				CFG_VOLUME:  volume_q  <= cfg_data;
				CFG_SMOOTH:  smooth_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end takes a transaction whenever the queue has room.
	sdrc_front #(
		.SW(SAMPLE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.left_in  (left_in),
		.right_in (right_in),
		.pop      (q_pop),
		.avail    (q_avail),
		.q_left   (q_left),
		.q_right  (q_right),
		.q_peak   (q_peak)
	);

	// The back end runs detector, gain computer and scaling, and holds the result in an
	// output register until the output transaction completes.
	sdrc_back #(
		.SW(SAMPLE_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.avail      (q_avail),
		.pop        (q_pop),
		.q_left     (q_left),
		.q_right    (q_right),
		.q_peak     (q_peak),
		.thresh     (thresh_q),
		.slope      (slope_q),
		.attack     (attack_q),
		.rel        (release_q),
		.volume     (volume_q),
		.smooth     (smooth_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.left_out   (left_out),
		.right_out  (right_out),
		.gain_level (gain_level)
	);

	// The sequencer only takes an entry that the queue really holds.
	a_pop_avail: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_avail)
		else $error("queue popped while empty");

	// The applied gain never exceeds unity, since rises are clamped at the target.
	a_gain_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gain_level <= GAIN_ONE))
		else $error("gain above unity");

	// A full queue must stop the input side.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !q_pop && q_avail) |=> !in_ready)
		else $error("queue overfilled");

endmodule

FILE: sv/sdrc_front.sv
module sdrc_front #(
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [SW-1:0] left_in,
	input  logic signed [SW-1:0] right_in,
	input  logic                 pop,
	output logic                 avail,
	output logic signed [SW-1:0] q_left,
	output logic signed [SW-1:0] q_right,
	output logic [31:0]          q_peak
);
	import sdrc_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	logic signed [SW-1:0] left_q  [QDEPTH];
	logic signed [SW-1:0] right_q [QDEPTH];
	logic [31:0]          peak_q  [QDEPTH];
	logic [PW-1:0]        wr_ptr_q;
	logic [PW-1:0]        rd_ptr_q;
	logic [PW:0]          count_q;
	logic [SW-1:0]        mag_l;
	logic [SW-1:0]        mag_r;
	logic [31:0]          peak;
	logic                 push;

	// Peak magnitude of the pair, aligned to Q1.31.
	assign mag_l = left_in[SW-1]  ? SW'(-left_in)  : SW'(left_in);
	assign mag_r = right_in[SW-1] ? SW'(-right_in) : SW'(right_in);
	assign peak  = 32'((mag_l > mag_r) ? mag_l : mag_r) << (32 - SW);

	assign in_ready = (count_q != (PW+1)'(QDEPTH));
	assign push     = in_valid && in_ready;
	assign avail    = (count_q != '0);
	assign q_left   = left_q[rd_ptr_q];
	assign q_right  = right_q[rd_ptr_q];
	assign q_peak   = peak_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			left_q[wr_ptr_q]  <= left_in;
			right_q[wr_ptr_q] <= right_in;
			peak_q[wr_ptr_q]  <= peak;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
			if (pop)
				rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: sv/sdrc_back.sv
module sdrc_back #(
	parameter int SW = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 avail,
	output logic                 pop,
	input  logic signed [SW-1:0] q_left,
	input  logic signed [SW-1:0] q_right,
	input  logic [31:0]          q_peak,
	input  logic [21:0]          thresh,
	input  logic [15:0]          slope,
	input  logic [23:0]          attack,
	input  logic [23:0]          rel,
	input  logic [23:0]          volume,
	input  logic [23:0]          smooth,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [SW-1:0] left_out,
	output logic signed [SW-1:0] right_out,
	output logic [24:0]          gain_level
);
	import sdrc_pkg::*;

	localparam logic [63:0] MAXP = (64'd1 << (SW - 1)) - 64'd1;

	st_t st_q, st_d;

	logic signed [SW-1:0] lx_q, rx_q, yl_q, yr_q;
	logic signed [SW-1:0] lo_q, ro_q;
	logic [31:0] p_q, ls_q, lv_q;
	logic [63:0] t_q, sx_q, res_q;
	logic [4:0]  cnt_q, n_q;
	logic [15:0] frac_q;
	logic [22:0] e_q;
	logic [30:0] acc_q;
	logic [24:0] tgt_q, gain_q, gv_q, go_q;
	logic        ov_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [63:0] sum_sm, ls_new64;
	logic [63:0] bitv, trial;
	logic [31:0] root, level;
	logic [31:0] sq;
	logic [5:0]  ip6;
	logic signed [21:0] lg, th;
	logic [22:0] diff;
	logic [6:0]  ip;
	logic [7:0]  shamt;
	logic        falling;
	logic [24:0] g_f;
	logic [32:0] g_r;
	logic [24:0] g_new;
	logic [SW-1:0] mag_l, mag_r;
	logic        out_free;

	function automatic logic [SW-1:0] sat(input logic neg, input logic [63:0] r);
		logic [SW-1:0] y;
		if (neg)
			y = (r > MAXP + 64'd1) ? SW'(MAXP + 64'd1) : SW'(64'd0 - r);
		else
			y = (r > MAXP) ? SW'(MAXP) : SW'(r);
		return y;
	endfunction

	assign mag_l = lx_q[SW-1] ? SW'(-lx_q) : SW'(lx_q);
	assign mag_r = rx_q[SW-1] ? SW'(-rx_q) : SW'(rx_q);

	assign falling = gain_q > tgt_q;

	// One shared multiplier; operands chosen by the step in progress.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (st_q)
			ST_SM1: begin
				mul_a = p_q;
				mul_b = 32'(smooth);
			end
			ST_SM2: begin
				mul_a = ls_q;
				mul_b = 32'(25'h1000000 - 25'(smooth));
			end
			ST_LOG: begin
				mul_a = lv_q;
				mul_b = lv_q;
			end
			ST_DIFF: begin
				mul_a = 32'(diff);
				mul_b = 32'(slope);
			end
			ST_EXP: begin
				mul_a = 32'(acc_q);
				mul_b = 32'(EXP_W[~cnt_q[3:0]]);
			end
			ST_GAIN: begin
				mul_a = 32'(gain_q);
				mul_b = falling ? 32'(attack) : 32'(rel);
			end
			ST_VOL: begin
				mul_a = 32'(gain_q);
				mul_b = 32'(volume);
			end
			ST_SCL_L: begin
				mul_a = 32'(mag_l);
				mul_b = 32'(gv_q);
			end
			ST_SCL_R: begin
				mul_a = 32'(mag_r);
				mul_b = 32'(gv_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = 64'(mul_a) * 64'(mul_b);
	assign sum_sm   = t_q + prod;
	assign ls_new64 = sum_sm >> 24;

	assign bitv  = 64'd1 << {cnt_q, 1'b0};
	assign trial = res_q + bitv;

	assign root  = res_q[31:0];
	assign level = (root > p_q) ? ((root == '0) ? 32'd1 : root)
	                            : ((p_q == '0) ? 32'd1 : p_q);

	assign sq = prod[61:30];

	assign ip6  = {1'b0, n_q} - 6'd31;
	assign lg   = signed'({ip6, frac_q});
	assign th   = signed'(thresh);
	assign diff = 23'({lg[21], lg}) - 23'({th[21], th});

	assign ip    = e_q[22:16];
	assign shamt = 8'd6 + {1'b0, ip};

	assign g_f   = prod[48:24];
	assign g_r   = prod[48:16];
	assign g_new = falling ? ((g_f > tgt_q) ? g_f : tgt_q)
	                       : ((g_r < 33'(tgt_q)) ? 25'(g_r) : tgt_q);

	assign out_free = !ov_q || out_ready;

	always_comb begin
		st_d = st_q;
		pop  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (avail) begin
					pop  = 1'b1;
					st_d = ST_SM1;
				end
			end
			ST_SM1:    st_d = ST_SM2;
			ST_SM2:    st_d = ST_SQRT;
			ST_SQRT:   if (cnt_q == '0) st_d = ST_LEVEL;
			ST_LEVEL:  st_d = ST_NORM;
			ST_NORM:   if (lv_q[31]) st_d = ST_LOG;
			ST_LOG:    if (cnt_q == '0) st_d = ST_DIFF;
			ST_DIFF:   st_d = (lg > th) ? ST_EXP : ST_GAIN;
			ST_EXP:    if (cnt_q == '0) st_d = ST_TARGET;
			ST_TARGET: st_d = ST_GAIN;
			ST_GAIN:   st_d = ST_VOL;
			ST_VOL:    st_d = ST_SCL_L;
			ST_SCL_L:  st_d = ST_SCL_R;
			ST_SCL_R:  st_d = ST_DONE;
			ST_DONE:   if (out_free) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

	// Persistent state and the output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ls_q   <= '0;
			gain_q <= GAIN_ONE;
			ov_q   <= 1'b0;
		end else begin
			if (st_q == ST_SM2)
				ls_q <= ls_new64[31:0];
			if (st_q == ST_GAIN)
				gain_q <= g_new;
			if (st_q == ST_DONE && out_free)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	// Working registers of the sequencer
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				lx_q <= q_left;
				rx_q <= q_right;
				p_q  <= q_peak;
			end
			ST_SM1: t_q <= prod;
			ST_SM2: begin
				sx_q  <= 64'(ls_new64[31:0]) << 31;
				res_q <= '0;
				cnt_q <= 5'd31;
			end
			ST_SQRT: begin
				if (sx_q >= trial) begin
					sx_q  <= sx_q - trial;
					res_q <= (res_q >> 1) + bitv;
				end else begin
					res_q <= res_q >> 1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
			ST_LEVEL: begin
				lv_q <= level;
				n_q  <= 5'd31;
			end
			ST_NORM: begin
				if (lv_q[31]) begin
					lv_q   <= {1'b0, lv_q[31:1]};
					cnt_q  <= 5'd15;
					frac_q <= '0;
				end else begin
					lv_q <= {lv_q[30:0], 1'b0};
					n_q  <= n_q - 1'b1;
				end
			end
			ST_LOG: begin
				lv_q   <= sq[31] ? {1'b0, sq[31:1]} : sq;
				frac_q <= {frac_q[14:0], sq[31]};
				cnt_q  <= cnt_q - 1'b1;
			end
			ST_DIFF: begin
				e_q   <= prod[38:16];
				acc_q <= 31'h40000000;
				cnt_q <= 5'd15;
				tgt_q <= GAIN_ONE;
			end
			ST_EXP: begin
				if (e_q[cnt_q[3:0]])
					acc_q <= prod[60:30];
				cnt_q <= cnt_q - 1'b1;
			end
			ST_TARGET: tgt_q <= (ip >= 7'd40) ? '0 : 25'(acc_q >> shamt);
			ST_VOL:    gv_q  <= prod[48:24];
			ST_SCL_L:  yl_q  <= sat(lx_q[SW-1], prod >> 20);
			ST_SCL_R:  yr_q  <= sat(rx_q[SW-1], prod >> 20);
			ST_DONE: begin
				if (out_free) begin
					lo_q <= yl_q;
					ro_q <= yr_q;
					go_q <= gain_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = ov_q;
	assign left_out   = lo_q;
	assign right_out  = ro_q;
	assign gain_level = go_q;

endmodule
